[rtl/core/tdpu_pkg.sv]
// shared types and constants of the thumb data processing unit
package tdpu_pkg;

    // instruction format prefixes, taken from bits [15:13] or [15:10]
    localparam logic [2:0] FMT_SHIFT_ADDSUB = 3'b000;
    localparam logic [2:0] FMT_IMM8         = 3'b001;
    localparam logic [5:0] FMT_ALU          = 6'b010000;

    // op field of the shift / add-subtract format, bits [12:11]
    localparam logic [1:0] SH_LSL    = 2'd0;
    localparam logic [1:0] SH_LSR    = 2'd1;
    localparam logic [1:0] SH_ASR    = 2'd2;
    localparam logic [1:0] SH_ADDSUB = 2'd3;

    // op field of the 8-bit immediate format, bits [12:11]
    localparam logic [1:0] IMM_MOV = 2'd0;
    localparam logic [1:0] IMM_CMP = 2'd1;
    localparam logic [1:0] IMM_ADD = 2'd2;
    localparam logic [1:0] IMM_SUB = 2'd3;

    // register alu operations, bits [9:6]
    typedef enum logic [3:0] {
        ALU_AND = 4'h0,
        ALU_EOR = 4'h1,
        ALU_LSL = 4'h2,
        ALU_LSR = 4'h3,
        ALU_ASR = 4'h4,
        ALU_ADC = 4'h5,
        ALU_SBC = 4'h6,
        ALU_ROR = 4'h7,
        ALU_TST = 4'h8,
        ALU_NEG = 4'h9,
        ALU_CMP = 4'hA,
        ALU_CMN = 4'hB,
        ALU_ORR = 4'hC,
        ALU_MUL = 4'hD,
        ALU_BIC = 4'hE,
        ALU_MVN = 4'hF
    } t_alu_op;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } t_flags;

    typedef struct packed {
        logic [2:0]  dest_index;
        logic [31:0] write_value;
        logic        write_enable;
        t_flags      flags;
        logic        unsupported;
    } t_exec_res;

endpackage

[rtl/core/tdpu_regfile.sv]
// eight 32-bit low registers, two registered read ports with write bypass
module tdpu_regfile (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rd_en,
    input  logic [2:0]  i_raddr_a,
    input  logic [2:0]  i_raddr_b,
    output logic [31:0] o_rdata_a,
    output logic [31:0] o_rdata_b,
    input  logic        i_wr_en,
    input  logic [2:0]  i_waddr,
    input  logic [31:0] i_wdata
);

    logic [31:0] r_mem [8];
    logic [7:0]  r_vld;
    logic [31:0] r_rdata_a;
    logic [31:0] r_rdata_b;

    // entries not yet written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_waddr == i_raddr_a)) begin
                r_rdata_a <= i_wdata;
            end else begin
                r_rdata_a <= r_vld[i_raddr_a] ? r_mem[i_raddr_a] : 32'd0;
            end
            if (i_wr_en && (i_waddr == i_raddr_b)) begin
                r_rdata_b <= i_wdata;
            end else begin
                r_rdata_b <= r_vld[i_raddr_b] ? r_mem[i_raddr_b] : 32'd0;
            end
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[rtl/core/tdpu_exec.sv]
// decode and execute of one thumb data processing instruction
module tdpu_exec (
    input  logic [15:0]          i_instruction,
    input  logic [31:0]          i_opa,
    input  logic [31:0]          i_opb,
    input  tdpu_pkg::t_flags     i_flags,
    output tdpu_pkg::t_exec_res  o_res
);

    logic [15:0]       ins;
    logic [31:0]       a;
    logic [31:0]       b;
    logic              is_fmt0;
    logic              is_fmt1;
    logic              is_alu;
    tdpu_pkg::t_alu_op alu_op;
    logic [31:0]       imm8;
    logic [31:0]       addsub_b;

    // shared adder
    logic [31:0] add_x;
    logic [31:0] add_y;
    logic        add_cin;
    logic [32:0] add_sum;
    logic [31:0] add_r;
    logic        add_c;
    logic        add_v;

    // shifter views
    logic [4:0]  imm_amt;
    logic [5:0]  imm_n;
    logic [32:0] lsl_i;
    logic [32:0] lsr_i;
    logic [32:0] asr_i;
    logic [7:0]  ramt;
    logic [5:0]  asr_n;
    logic [32:0] lsl_r;
    logic [32:0] lsr_r;
    logic [32:0] asr_r;
    logic [63:0] ror_d;
    logic [31:0] mul_v;

    logic [31:0] val;
    logic [2:0]  dest;
    logic        wr;
    logic        unsup;
    logic        c_new;
    logic        v_new;

    assign ins      = i_instruction;
    assign a        = i_opa;
    assign b        = i_opb;
    assign is_fmt0  = (ins[15:13] == tdpu_pkg::FMT_SHIFT_ADDSUB);
    assign is_fmt1  = (ins[15:13] == tdpu_pkg::FMT_IMM8);
    assign is_alu   = (ins[15:10] == tdpu_pkg::FMT_ALU);
    assign alu_op   = tdpu_pkg::t_alu_op'(ins[9:6]);
    assign imm8     = {24'd0, ins[7:0]};
    assign addsub_b = ins[10] ? {29'd0, ins[8:6]} : b;

    // adder operand selection
    always_comb begin
        add_x   = a;
        add_y   = b;
        add_cin = 1'b0;
        if (is_fmt0) begin
            add_y   = ins[9] ? ~addsub_b : addsub_b;
            add_cin = ins[9];
        end else if (is_fmt1) begin
            add_y   = (ins[12:11] == tdpu_pkg::IMM_ADD) ? imm8 : ~imm8;
            add_cin = (ins[12:11] != tdpu_pkg::IMM_ADD);
        end else begin
            unique case (alu_op)
                tdpu_pkg::ALU_ADC: begin
                    add_cin = i_flags.c;
                end
                tdpu_pkg::ALU_SBC: begin
                    add_y   = ~b;
                    add_cin = i_flags.c;
                end
                tdpu_pkg::ALU_NEG: begin
                    add_x   = 32'd0;
                    add_y   = ~b;
                    add_cin = 1'b1;
                end
                tdpu_pkg::ALU_CMP: begin
                    add_y   = ~b;
                    add_cin = 1'b1;
                end
                default: begin
                    add_cin = 1'b0;
                end
            endcase
        end
    end

    assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_cin};
    assign add_r   = add_sum[31:0];
    assign add_c   = add_sum[32];
    assign add_v   = ~(add_x[31] ^ add_y[31]) & (add_x[31] ^ add_r[31]);

    // immediate shifts: lsr and asr by zero mean by 32
    assign imm_amt = ins[10:6];
    assign imm_n   = (imm_amt == 5'd0) ? 6'd32 : {1'b0, imm_amt};
    assign lsl_i   = {1'b0, a} << imm_amt;
    assign lsr_i   = {a, 1'b0} >> imm_n;
    assign asr_i   = 33'($signed({a, 1'b0}) >>> imm_n);

    // register shifts: amount is the low byte, the last bit shifted out gives carry
    assign ramt  = b[7:0];
    assign asr_n = (ramt >= 8'd32) ? 6'd32 : ramt[5:0];
    assign lsl_r = {1'b0, a} << ramt;
    assign lsr_r = {a, 1'b0} >> ramt;
    assign asr_r = 33'($signed({a, 1'b0}) >>> asr_n);
    assign ror_d = {a, a} >> b[4:0];
    assign mul_v = a * b;

    always_comb begin
        val   = 32'd0;
        dest  = ins[2:0];
        wr    = 1'b1;
        unsup = 1'b0;
        c_new = i_flags.c;
        v_new = i_flags.v;
        if (is_fmt0) begin
            unique case (ins[12:11])
                tdpu_pkg::SH_LSL: begin
                    val = a;
                    if (imm_amt != 5'd0) begin
                        val   = lsl_i[31:0];
                        c_new = lsl_i[32];
                    end
                end
                tdpu_pkg::SH_LSR: begin
                    val   = lsr_i[32:1];
                    c_new = lsr_i[0];
                end
                tdpu_pkg::SH_ASR: begin
                    val   = asr_i[32:1];
                    c_new = asr_i[0];
                end
                tdpu_pkg::SH_ADDSUB: begin
                    val   = add_r;
                    c_new = add_c;
                    v_new = add_v;
                end
            endcase
        end else if (is_fmt1) begin
            dest = ins[10:8];
            if (ins[12:11] == tdpu_pkg::IMM_MOV) begin
                val = imm8;
            end else begin
                val   = add_r;
                c_new = add_c;
                v_new = add_v;
                wr    = (ins[12:11] != tdpu_pkg::IMM_CMP);
            end
        end else if (is_alu) begin
            unique case (alu_op)
                tdpu_pkg::ALU_AND: val = a & b;
                tdpu_pkg::ALU_EOR: val = a ^ b;
                tdpu_pkg::ALU_LSL: begin
                    val = a;
                    if (ramt != 8'd0) begin
                        val   = lsl_r[31:0];
                        c_new = lsl_r[32];
                    end
                end
                tdpu_pkg::ALU_LSR: begin
                    val = a;
                    if (ramt != 8'd0) begin
                        val   = lsr_r[32:1];
                        c_new = lsr_r[0];
                    end
                end
                tdpu_pkg::ALU_ASR: begin
                    val = a;
                    if (ramt != 8'd0) begin
                        val   = asr_r[32:1];
                        c_new = asr_r[0];
                    end
                end
                tdpu_pkg::ALU_ROR: begin
                    val = a;
                    if (ramt != 8'd0) begin
                        val   = ror_d[31:0];
                        c_new = ror_d[31];
                    end
                end
                tdpu_pkg::ALU_ADC, tdpu_pkg::ALU_SBC, tdpu_pkg::ALU_NEG: begin
                    val   = add_r;
                    c_new = add_c;
                    v_new = add_v;
                end
                tdpu_pkg::ALU_CMP, tdpu_pkg::ALU_CMN: begin
                    val   = add_r;
                    c_new = add_c;
                    v_new = add_v;
                    wr    = 1'b0;
                end
                tdpu_pkg::ALU_TST: begin
                    val = a & b;
                    wr  = 1'b0;
                end
                tdpu_pkg::ALU_ORR: val = a | b;
                tdpu_pkg::ALU_MUL: val = mul_v;
                tdpu_pkg::ALU_BIC: val = a & ~b;
                tdpu_pkg::ALU_MVN: val = ~b;
            endcase
        end else begin
            unsup = 1'b1;
            wr    = 1'b0;
        end
    end

    always_comb begin
        o_res.dest_index   = wr ? dest : 3'd0;
        o_res.write_value  = wr ? val : 32'd0;
        o_res.write_enable = wr;
        o_res.unsupported  = unsup;
        if (unsup) begin
            o_res.flags = i_flags;
        end else begin
            o_res.flags.n = val[31];
            o_res.flags.z = (val == 32'd0);
            o_res.flags.c = c_new;
            o_res.flags.v = v_new;
        end
    end

endmodule

[rtl/core/thumb_data_processing_unit.sv]
// top level of the thumb data processing unit
// usage:
// - input channel i_in_valid / o_in_ready carries one 16-bit thumb instruction per item
// - output channel o_out_valid / i_out_ready carries one result item per instruction:
//   destination register, written value, write enable, n z c v flags, unsupported
// - accepting an instruction reads its two register operands into the input stage;
//   executing it loads the result register, which makes the result valid, while
//   writing the register file and the flags
// - throughput is one item per cycle while the receiver takes results; the execute
//   path (adder, shifter, 32x32 multiplier low half) is combinational
// - a result depends on the previous one through the register file; the operand
//   read bypasses the write that lands on the same edge, so no bubbles are needed
// - when the receiver stalls, the result register holds its item and the input
//   stage fills; once both are full o_in_ready drops until the result is taken
// - reset (synchronous, active low) empties both stages and clears all eight low
//   registers and the flags to zero
// - unsupported encodings give a result with unsupported set and change no state
module thumb_data_processing_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_instruction,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_dest_index,
    output logic [31:0] o_write_value,
    output logic        o_write_enable,
    output logic        o_flag_neg,
    output logic        o_flag_zero,
    output logic        o_flag_carry,
    output logic        o_flag_overflow,
    output logic        o_unsupported
);

    // operand a: source of shifts and add/sub, rd of immediate and alu forms
    function automatic logic [2:0] f_addr_a(input logic [15:0] ins);
        logic [2:0] addr;
        addr = ins[2:0];
        if (ins[15:13] == tdpu_pkg::FMT_SHIFT_ADDSUB) begin
            addr = ins[5:3];
        end else if (ins[15:13] == tdpu_pkg::FMT_IMM8) begin
            addr = ins[10:8];
        end
        return addr;
    endfunction

    // operand b: second register of add/sub, rs of alu forms
    function automatic logic [2:0] f_addr_b(input logic [15:0] ins);
        logic [2:0] addr;
        addr = ins[5:3];
        if (ins[15:13] == tdpu_pkg::FMT_SHIFT_ADDSUB) begin
            addr = ins[8:6];
        end
        return addr;
    endfunction

    logic                 in_accept;
    logic                 fire;
    logic                 r_in_vld;
    logic [15:0]          r_ins;
    logic                 r_out_vld;
    tdpu_pkg::t_exec_res  r_out;
    tdpu_pkg::t_flags     r_flags;
    logic [31:0]          opa;
    logic [31:0]          opb;
    tdpu_pkg::t_exec_res  exec_res;

    // execute when the input stage is full and the result slot is free or draining
    assign fire       = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || fire;
    assign in_accept  = i_in_valid && o_in_ready;

    tdpu_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_accept),
        .i_raddr_a (f_addr_a(i_instruction)),
        .i_raddr_b (f_addr_b(i_instruction)),
        .o_rdata_a (opa),
        .o_rdata_b (opb),
        .i_wr_en   (fire && exec_res.write_enable),
        .i_waddr   (exec_res.dest_index),
        .i_wdata   (exec_res.write_value)
    );

    tdpu_exec u_exec (
        .i_instruction (r_ins),
        .i_opa         (opa),
        .i_opb         (opb),
        .i_flags       (r_flags),
        .o_res         (exec_res)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_accept) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_ins <= i_instruction;
        end
    end

    // flags, unchanged by unsupported items since exec passes them through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (fire) begin
            r_flags <= exec_res.flags;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= exec_res;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_dest_index    = r_out.dest_index;
    assign o_write_value   = r_out.write_value;
    assign o_write_enable  = r_out.write_enable;
    assign o_flag_neg      = r_out.flags.n;
    assign o_flag_zero     = r_out.flags.z;
    assign o_flag_carry    = r_out.flags.c;
    assign o_flag_overflow = r_out.flags.v;
    assign o_unsupported   = r_out.unsupported;

endmodule
